[rtl/mft_pkg.sv]
package mft_pkg;

	localparam int MaxEntries = 16;

	localparam int CmdW   = 4;
	localparam int AddrW  = 64;
	localparam int WidthW = 2;
	localparam int ValW   = 64;
	localparam int SlotW  = 4;
	localparam int KindW  = 2;

	// s_tdata: address, width_code, data_value, slot, zero fill to 17 bytes
	localparam int InDataW  = 136;
	// m_tdata: out_address, out_width, out_value, out_slot, found, overflow
	localparam int OutDataW = 136;

	localparam logic [CmdW-1:0] CMD_TICK     = 4'd0;
	localparam logic [CmdW-1:0] CMD_FREEZE   = 4'd1;
	localparam logic [CmdW-1:0] CMD_UNFREEZE = 4'd2;
	localparam logic [CmdW-1:0] CMD_QUERY    = 4'd3;
	localparam logic [CmdW-1:0] CMD_SET      = 4'd4;
	localparam logic [CmdW-1:0] CMD_CLEAR    = 4'd5;
	localparam logic [CmdW-1:0] CMD_REFRESH  = 4'd6;
	localparam logic [CmdW-1:0] CMD_LOAD     = 4'd7;
	localparam logic [CmdW-1:0] CMD_LIST     = 4'd8;

	localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
	localparam logic [KindW-1:0] KIND_READ  = 2'd1;
	localparam logic [KindW-1:0] KIND_RESP  = 2'd2;
	localparam logic [KindW-1:0] KIND_ENTRY = 2'd3;

	localparam logic [WidthW-1:0] WC_BYTE  = 2'd0;
	localparam logic [WidthW-1:0] WC_HALF  = 2'd1;
	localparam logic [WidthW-1:0] WC_WORD  = 2'd2;

	typedef struct packed {
		logic [AddrW-1:0]  addr;
		logic [WidthW-1:0] width;
		logic [ValW-1:0]   value;
	} entry_t;

	// ring control: step moves every cell one place toward the head;
	// shrink parks the tail cell and closes the ring one cell short
	typedef struct packed {
		logic step;
		logic shrink;
	} ring_ctl_t;

	function automatic logic [ValW-1:0] width_mask(input logic [WidthW-1:0] code);
		logic [ValW-1:0] m;
		case (code)
			WC_BYTE: m = {{(ValW-8){1'b0}}, {8{1'b1}}};
			WC_HALF: m = {{(ValW-16){1'b0}}, {16{1'b1}}};
			WC_WORD: m = {{(ValW-32){1'b0}}, {32{1'b1}}};
			default: m = {ValW{1'b1}};
		endcase
		return m;
	endfunction

endpackage

[rtl/mft_cell.sv]
module mft_cell (
	input  logic            clk,
	input  logic            en,
	input  mft_pkg::entry_t d,
	output mft_pkg::entry_t q
);
	import mft_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

[rtl/mft_chain.sv]
module mft_chain #(
	parameter int MAX_ENTRIES = mft_pkg::MaxEntries
) (
	input  logic               clk,
	input  mft_pkg::ring_ctl_t ctl,
	input  mft_pkg::entry_t    tail_in,
	output mft_pkg::entry_t    head
);
	import mft_pkg::*;

	entry_t q [MAX_ENTRIES];

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t d;
		logic   en;

		if (i == MAX_ENTRIES - 1) begin : g_tail
			// parked while the ring runs short after a removal
			assign d  = tail_in;
			assign en = ctl.step && !ctl.shrink;
		end else if (i == MAX_ENTRIES - 2) begin : g_pre_tail
			assign d  = ctl.shrink ? tail_in : q[i+1];
			assign en = ctl.step;
		end else begin : g_mid
			assign d  = q[i+1];
			assign en = ctl.step;
		end

		mft_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (d),
			.q   (q[i])
		);
	end

	assign head = q[0];

endmodule

[rtl/memory_freeze_table_core.sv]
// Working commands rotate the entries once around a ring of MAX_ENTRIES cells past
// one head compare unit, one position a cycle. Sweep results come one a cycle, the
// first registered from the head at the first ring step; single responses are
// registered at the last step of the rotation. Ignored commands and empty sweeps
// do not start the ring. Output stalls pause the ring.
// arst_n clears control, count and enforce_enable; entry storage is not cleared.
module memory_freeze_table_core #(
	parameter int MAX_ENTRIES = mft_pkg::MaxEntries
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,   // enforce_enable

	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [63:0] address, [65:64] width_code, [129:66] data_value, [133:130] slot
	input  logic [mft_pkg::InDataW-1:0]  s_tdata,
	input  logic [mft_pkg::CmdW-1:0]     s_tuser,    // [3:0] command

	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [63:0] out_address, [65:64] out_width, [129:66] out_value,
	// [133:130] out_slot, [134] found, [135] overflow
	output logic [mft_pkg::OutDataW-1:0] m_tdata,
	output logic [mft_pkg::KindW-1:0]    m_tuser,    // [1:0] kind
	output logic                         m_tlast
);
	import mft_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = (CW > SlotW) ? CW : SlotW;

	logic              enforce_q;
	logic [CW-1:0]     count_q;
	logic              busy_q;
	logic [CW-1:0]     k_q;
	logic              hit_q;
	logic              shrink_q;

	logic [CmdW-1:0]   cmd_q;
	logic [AddrW-1:0]  addr_q;
	logic [WidthW-1:0] wc_q;
	logic [ValW-1:0]   data_q;
	logic [SlotW-1:0]  slot_q;
	entry_t            cap_q;
	logic [CW-1:0]     cap_pos_q;

	logic              m_tvalid_q;
	logic [KindW-1:0]  o_kind_q;
	logic [AddrW-1:0]  o_addr_q;
	logic [WidthW-1:0] o_width_q;
	logic [ValW-1:0]   o_value_q;
	logic [SlotW-1:0]  o_slot_q;
	logic              o_found_q;
	logic              o_ovf_q;
	logic              o_last_q;

	ring_ctl_t         ctl;
	entry_t            head;
	entry_t            tail_in;

	logic [CmdW-1:0]   in_cmd;
	logic              start;
	logic              step_go;
	logic              is_search;
	logic              is_sweep;
	logic              in_range;
	logic              last_step;
	logic              match_now;
	logic              load_now;
	logic              append_now;
	logic              slot_ok;
	logic              full;
	logic [SW-1:0]     k_ext;
	logic              emit;
	logic [KindW-1:0]  e_kind;
	logic [AddrW-1:0]  e_addr;
	logic [WidthW-1:0] e_width;
	logic [ValW-1:0]   e_value;
	logic [SlotW-1:0]  e_slot;
	logic              e_found;
	logic              e_ovf;
	logic              e_last;
	entry_t            hit_entry;
	logic [CW-1:0]     hit_pos;
	logic              hit_any;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign in_cmd    = s_tuser;

	always_comb begin
		case (in_cmd)
			CMD_FREEZE, CMD_UNFREEZE, CMD_QUERY, CMD_SET, CMD_CLEAR, CMD_LOAD:
				start = 1'b1;
			CMD_TICK:
				start = enforce_q && (count_q != '0);
			CMD_REFRESH, CMD_LIST:
				start = count_q != '0;
			default:
				start = 1'b0;
		endcase
	end

	assign step_go    = busy_q && !(m_tvalid_q && !m_tready);
	assign is_search  = (cmd_q == CMD_UNFREEZE) || (cmd_q == CMD_QUERY) || (cmd_q == CMD_SET);
	assign is_sweep   = (cmd_q == CMD_TICK) || (cmd_q == CMD_REFRESH) || (cmd_q == CMD_LIST);
	assign in_range   = k_q < count_q;
	assign last_step  = k_q == CW'(MAX_ENTRIES - 1);
	assign k_ext      = SW'(k_q);
	assign slot_ok    = SW'(slot_q) < SW'(count_q);
	assign full       = count_q == CW'(MAX_ENTRIES);

	assign match_now  = is_search && in_range && !hit_q && (head.addr == addr_q);
	assign load_now   = (cmd_q == CMD_LOAD) && slot_ok && (k_ext == SW'(slot_q));
	assign append_now = (cmd_q == CMD_FREEZE) && (k_q == count_q);

	// head goes back in at the tail, with an edit when this is its slot
	always_comb begin
		tail_in = head;
		if (append_now) begin
			tail_in.addr  = addr_q;
			tail_in.width = wc_q;
			tail_in.value = data_q & width_mask(wc_q);
		end else if (load_now) begin
			tail_in.value = data_q & width_mask(head.width);
		end else if (match_now && (cmd_q == CMD_SET)) begin
			tail_in.value = data_q;
		end
	end

	assign ctl.step   = step_go;
	assign ctl.shrink = shrink_q;

	mft_chain #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.tail_in (tail_in),
		.head    (head)
	);

	assign hit_any   = hit_q || match_now || load_now;
	assign hit_entry = (match_now || load_now) ? tail_in : cap_q;
	assign hit_pos   = (match_now || load_now) ? k_q : cap_pos_q;

	always_comb begin
		emit    = 1'b0;
		e_kind  = KIND_RESP;
		e_addr  = '0;
		e_width = '0;
		e_value = '0;
		e_slot  = '0;
		e_found = 1'b0;
		e_ovf   = 1'b0;
		e_last  = 1'b1;
		if (is_sweep) begin
			emit    = in_range;
			e_addr  = head.addr;
			e_width = head.width;
			e_slot  = k_ext[SlotW-1:0];
			e_last  = k_q == (count_q - CW'(1));
			case (cmd_q)
				CMD_TICK: begin
					e_kind  = KIND_WRITE;
					e_value = head.value & width_mask(head.width);
				end
				CMD_REFRESH: begin
					e_kind  = KIND_READ;
				end
				default: begin
					e_kind  = KIND_ENTRY;
					e_value = head.value;
				end
			endcase
		end else begin
			emit = last_step;
			case (cmd_q)
				CMD_FREEZE: begin
					e_addr  = addr_q;
					e_width = wc_q;
					if (full) begin
						e_ovf   = 1'b1;
					end else begin
						e_value = data_q & width_mask(wc_q);
						e_slot  = SlotW'(SW'(count_q));
					end
				end
				CMD_LOAD: begin
					e_slot = slot_q;
					if (hit_any) begin
						e_found = 1'b1;
						e_addr  = hit_entry.addr;
						e_width = hit_entry.width;
						e_value = hit_entry.value;
					end
				end
				CMD_CLEAR: begin
					e_addr = '0;
				end
				default: begin
					if (hit_any) begin
						e_found = 1'b1;
						e_addr  = hit_entry.addr;
						e_width = hit_entry.width;
						e_value = hit_entry.value;
						e_slot  = SlotW'(SW'(hit_pos));
					end else begin
						e_addr = addr_q;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q  <= 1'b0;
			count_q    <= '0;
			busy_q     <= 1'b0;
			k_q        <= '0;
			hit_q      <= 1'b0;
			shrink_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enforce_q <= cfg_data;
			end

			if (s_tvalid && s_tready && start) begin
				busy_q   <= 1'b1;
				k_q      <= '0;
				hit_q    <= 1'b0;
				shrink_q <= 1'b0;
			end else if (step_go) begin
				k_q <= k_q + CW'(1);
				if (match_now || load_now) begin
					hit_q <= 1'b1;
				end
				if (match_now && (cmd_q == CMD_UNFREEZE)) begin
					shrink_q <= 1'b1;
				end
				if (last_step) begin
					busy_q   <= 1'b0;
					shrink_q <= 1'b0;
					case (cmd_q)
						CMD_FREEZE: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end
						CMD_UNFREEZE: begin
							if (hit_any) begin
								count_q <= count_q - CW'(1);
							end
						end
						CMD_CLEAR: begin
							count_q <= '0;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
			end

			if (step_go && emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= in_cmd;
			addr_q <= s_tdata[63:0];
			wc_q   <= s_tdata[65:64];
			data_q <= s_tdata[129:66];
			slot_q <= s_tdata[133:130];
		end
		if (step_go && (match_now || load_now)) begin
			cap_q     <= tail_in;
			cap_pos_q <= k_q;
		end
		if (step_go && emit) begin
			o_kind_q  <= e_kind;
			o_addr_q  <= e_addr;
			o_width_q <= e_width;
			o_value_q <= e_value;
			o_slot_q  <= e_slot;
			o_found_q <= e_found;
			o_ovf_q   <= e_ovf;
			o_last_q  <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {o_ovf_q, o_found_q, o_slot_q, o_value_q, o_width_q, o_addr_q};

endmodule

[rtl/mft_checker.sv]
module mft_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mft_pkg::OutDataW-1:0] m_tdata,
	input logic [mft_pkg::KindW-1:0]    m_tuser,
	input logic                         m_tlast
);
	import mft_pkg::*;

	// a result only appears while a command is in progress
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with the block idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// overflow is a single refused-freeze response
	a_overflow_resp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[135] |->
			m_tlast && (m_tuser == KIND_RESP) && !m_tdata[134] && (m_tdata[129:66] == '0))
		else $error("bad overflow response");

	a_sweep_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_RESP) |->
			!m_tdata[134] && !m_tdata[135] && ((m_tuser != KIND_READ) || (m_tdata[129:66] == '0)))
		else $error("sweep result carries response flags or read value");

endmodule

bind memory_freeze_table_core mft_checker u_mft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mft_pkg::*;

	localparam int Depth = MaxEntries;
	localparam logic [WidthW-1:0] WC_DWORD = 2'd3;
	localparam logic [CmdW-1:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [CmdW-1:0] CMD_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [CmdW-1:0]   cmd;
		logic [AddrW-1:0]  addr;
		logic [WidthW-1:0] wc;
		logic [ValW-1:0]   data;
		logic [SlotW-1:0]  slot;
	} freeze_cmd_t;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [AddrW-1:0]  addr;
		logic [WidthW-1:0] width;
		logic [ValW-1:0]   value;
		logic [SlotW-1:0]  slot;
		logic              found;
		logic              ovf;
		logic              last;
	} freeze_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic [CmdW-1:0]     s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic [KindW-1:0]    m_tuser;
	logic                m_tlast;

	memory_freeze_table_core #(.MAX_ENTRIES(Depth)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	freeze_cmd_t cmd_backlog[$];
	freeze_out_t table_outputs_due[$];

	// shadow of the frozen table and the enable register
	logic [AddrW-1:0]  tbl_addr[Depth];
	logic [WidthW-1:0] tbl_width[Depth];
	logic [ValW-1:0]   tbl_value[Depth];
	int                tbl_count;
	logic              tick_enable;

	logic [AddrW-1:0] addr_pool[8];
	int send_idle_pct;
	int recv_idle_pct;
	int send_gap;
	int recv_gap;
	freeze_cmd_t next_cmd;
	freeze_cmd_t bus_cmd;
	freeze_out_t got;

	int fail_count;
	int cmds_taken;
	int outputs_checked;
	int overflows_predicted;
	int writes_predicted;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [ValW-1:0] value_mask(input logic [WidthW-1:0] wc);
		return {ValW{1'b1}} >> (64 - (8 << wc));
	endfunction

	function automatic void add_output(input logic [KindW-1:0] kind,
			input logic [AddrW-1:0] a, input logic [WidthW-1:0] w,
			input logic [ValW-1:0] v, input logic [SlotW-1:0] s,
			input logic f, input logic o, input logic l);
		freeze_out_t r;
		r.kind = kind;
		r.addr = a;
		r.width = w;
		r.value = v;
		r.slot = s;
		r.found = f;
		r.ovf = o;
		r.last = l;
		table_outputs_due = {table_outputs_due, r};
	endfunction

	// applies one accepted command to the shadow table, queues what it emits
	task automatic run_table_cmd(input freeze_cmd_t c);
		int n;
		int hit;
		n = tbl_count;
		hit = -1;
		case (c.cmd)
			CMD_TICK: begin
				if (tick_enable) begin
					for (int i = 0; i < n; i++) begin
						add_output(KIND_WRITE, tbl_addr[i], tbl_width[i],
							tbl_value[i] & value_mask(tbl_width[i]), SlotW'(i),
							1'b0, 1'b0, i == n - 1);
						writes_predicted++;
					end
				end
			end
			CMD_FREEZE: begin
				if (n >= Depth) begin
					add_output(KIND_RESP, c.addr, c.wc, '0, '0, 1'b0, 1'b1, 1'b1);
					overflows_predicted++;
				end else begin
					tbl_addr[n] = c.addr;
					tbl_width[n] = c.wc;
					tbl_value[n] = c.data & value_mask(c.wc);
					tbl_count = n + 1;
					add_output(KIND_RESP, c.addr, c.wc, tbl_value[n], SlotW'(n),
						1'b0, 1'b0, 1'b1);
				end
			end
			CMD_UNFREEZE, CMD_QUERY, CMD_SET: begin
				for (int i = 0; i < n; i++)
					if (hit < 0 && tbl_addr[i] == c.addr)
						hit = i;
				if (hit < 0) begin
					add_output(KIND_RESP, c.addr, '0, '0, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					if (c.cmd == CMD_SET)
						tbl_value[hit] = c.data;
					add_output(KIND_RESP, tbl_addr[hit], tbl_width[hit], tbl_value[hit],
						SlotW'(hit), 1'b1, 1'b0, 1'b1);
					if (c.cmd == CMD_UNFREEZE) begin
						for (int i = hit; i < n - 1; i++) begin
							tbl_addr[i] = tbl_addr[i + 1];
							tbl_width[i] = tbl_width[i + 1];
							tbl_value[i] = tbl_value[i + 1];
						end
						tbl_count = n - 1;
					end
				end
			end
			CMD_CLEAR: begin
				tbl_count = 0;
				add_output(KIND_RESP, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
			end
			CMD_REFRESH, CMD_LIST: begin
				for (int i = 0; i < n; i++)
					add_output(c.cmd == CMD_REFRESH ? KIND_READ : KIND_ENTRY, tbl_addr[i],
						tbl_width[i], c.cmd == CMD_REFRESH ? '0 : tbl_value[i], SlotW'(i),
						1'b0, 1'b0, i == n - 1);
			end
			CMD_LOAD: begin
				if (c.slot < n) begin
					tbl_value[c.slot] = c.data & value_mask(tbl_width[c.slot]);
					add_output(KIND_RESP, tbl_addr[c.slot], tbl_width[c.slot],
						tbl_value[c.slot], c.slot, 1'b1, 1'b0, 1'b1);
				end else begin
					add_output(KIND_RESP, '0, '0, '0, c.slot, 1'b0, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (seen !== want) begin
			$error("%s: expected %h, got %h", name, want, seen);
			fail_count++;
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (cmd_backlog.size() > 0) begin
				next_cmd = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_cmd.cmd;
				s_tdata <= {2'b00, next_cmd.slot, next_cmd.data, next_cmd.wc, next_cmd.addr};
				if ($urandom_range(99) < send_idle_pct)
					send_gap <= $urandom_range(1, 17);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: tracks accepted commands and config, checks each output transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			tbl_count = 0;
			tick_enable = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				tick_enable = cfg_data;
			if (s_tvalid && s_tready) begin
				bus_cmd.cmd = s_tuser;
				bus_cmd.addr = s_tdata[63:0];
				bus_cmd.wc = s_tdata[65:64];
				bus_cmd.data = s_tdata[129:66];
				bus_cmd.slot = s_tdata[133:130];
				run_table_cmd(bus_cmd);
				cmds_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.addr = m_tdata[63:0];
				got.width = m_tdata[65:64];
				got.value = m_tdata[129:66];
				got.slot = m_tdata[133:130];
				got.found = m_tdata[134];
				got.ovf = m_tdata[135];
				got.last = m_tlast;
				outputs_checked++;
				if (table_outputs_due.size() == 0) begin
					$error("output with none expected: kind %0d address %h", got.kind, got.addr);
					fail_count++;
				end else begin
					compare_field("kind", 64'(table_outputs_due[0].kind), 64'(got.kind));
					compare_field("out_address", table_outputs_due[0].addr, got.addr);
					compare_field("out_width", 64'(table_outputs_due[0].width),
						64'(got.width));
					compare_field("out_value", table_outputs_due[0].value, got.value);
					compare_field("out_slot", 64'(table_outputs_due[0].slot), 64'(got.slot));
					compare_field("found", 64'(table_outputs_due[0].found), 64'(got.found));
					compare_field("overflow", 64'(table_outputs_due[0].ovf), 64'(got.ovf));
					compare_field("last", 64'(table_outputs_due[0].last), 64'(got.last));
					void'(table_outputs_due.pop_front());
				end
			end
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(99) < recv_idle_pct)
					recv_gap <= $urandom_range(1, 17);
			end
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [AddrW-1:0] pick_addr();
		if ($urandom_range(3) != 0)
			return addr_pool[3'($urandom_range(7))];
		return rand_word();
	endfunction

	function automatic freeze_cmd_t random_fields();
		freeze_cmd_t c;
		c.cmd = CMD_QUERY;
		c.addr = pick_addr();
		c.wc = WidthW'($urandom_range(3));
		c.data = rand_word();
		c.slot = SlotW'($urandom_range(15));
		return c;
	endfunction

	task automatic queue_cmd(input logic [CmdW-1:0] cmd, input logic [AddrW-1:0] a,
			input logic [WidthW-1:0] wc, input logic [ValW-1:0] d,
			input logic [SlotW-1:0] s);
		freeze_cmd_t c;
		c.cmd = cmd;
		c.addr = a;
		c.wc = wc;
		c.data = d;
		c.slot = s;
		cmd_backlog = {cmd_backlog, c};
	endtask

	task automatic queue_table_op();
		freeze_cmd_t c;
		c = random_fields();
		case ($urandom_range(11))
			0, 1, 2: c.cmd = CMD_FREEZE;
			3: c.cmd = CMD_UNFREEZE;
			4, 5: c.cmd = CMD_QUERY;
			6: c.cmd = CMD_SET;
			7: c.cmd = CMD_LOAD;
			8: c.cmd = CMD_TICK;
			9: c.cmd = CMD_REFRESH;
			10: c.cmd = CMD_LIST;
			default: c.cmd = CMD_CLEAR;
		endcase
		cmd_backlog = {cmd_backlog, c};
	endtask

	// mostly rebuilds and works a table with pooled addresses, some raw noise
	task automatic queue_random_cmds(input int quota);
		int made;
		int pick;
		freeze_cmd_t c;
		made = 0;
		while (made < quota) begin
			pick = $urandom_range(9);
			if (pick < 3) begin
				c = random_fields();
				c.cmd = CMD_CLEAR;
				cmd_backlog = {cmd_backlog, c};
				made++;
				repeat ($urandom_range(1, Depth + 2)) begin
					c = random_fields();
					c.cmd = CMD_FREEZE;
					cmd_backlog = {cmd_backlog, c};
					made++;
				end
				repeat ($urandom_range(3, 8)) begin
					queue_table_op();
					made++;
				end
			end else if (pick < 9) begin
				repeat ($urandom_range(2, 6)) begin
					queue_table_op();
					made++;
				end
			end else begin
				c = random_fields();
				c.addr = rand_word();
				c.cmd = CmdW'($urandom_range(CMD_UNUSED_HI));
				cmd_backlog = {cmd_backlog, c};
				if (c.cmd <= CMD_LIST)
					made++;
			end
		end
	endtask

	task automatic write_enforce(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// hold off until all commands are taken and every output is back
	task automatic settle();
		while (cmd_backlog.size() != 0 || s_tvalid || table_outputs_due.size() != 0)
			@(posedge clk);
		repeat (Depth + 4) @(posedge clk);
	endtask

	initial begin
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			addr_pool[i] = {$urandom, $urandom};
		send_idle_pct = 20;
		recv_idle_pct = 20;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_enforce(1'b0);

		queue_cmd(CMD_TICK, '1, WC_DWORD, '1, '1);
		queue_cmd(CMD_LIST, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_REFRESH, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_QUERY, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_LOAD, '0, WC_BYTE, '1, '0);
		queue_cmd(CMD_FREEZE, '0, WC_BYTE, '1, '0);
		queue_cmd(CMD_FREEZE, '1, WC_DWORD, '1, '1);
		queue_cmd(CMD_FREEZE, 64'h8000_0000_0000_0001, WC_HALF, 64'h1234_5678_9abc_def0, '0);
		// same address again: lookups must pick the lower slot
		queue_cmd(CMD_FREEZE, '0, WC_WORD, 64'hdead_beef_cafe_f00d, '0);
		queue_cmd(CMD_TICK, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_LIST, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_REFRESH, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_QUERY, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_SET, '0, WC_BYTE, '1, '0);
		queue_cmd(CMD_LOAD, '0, WC_BYTE, '1, 4'd3);
		queue_cmd(CMD_LOAD, '0, WC_BYTE, '1, '1);
		queue_cmd(CMD_LOAD, '0, WC_BYTE, '1, 4'd4);
		queue_cmd(CMD_UNFREEZE, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_QUERY, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_UNFREEZE, 64'h5555_aaaa_5555_aaaa, WC_BYTE, '0, '0);
		queue_cmd(CMD_SET, 64'h5555_aaaa_5555_aaaa, WC_BYTE, '1, '0);
		queue_cmd(CMD_UNUSED_LO, '1, WC_DWORD, '1, '1);
		queue_cmd(CMD_UNUSED_HI, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_LIST, '0, WC_BYTE, '0, '0);
		queue_cmd(CMD_CLEAR, '1, WC_DWORD, '1, '1);
		queue_cmd(CMD_LIST, '0, WC_BYTE, '0, '0);
		settle();

		write_enforce(1'b1);
		send_idle_pct = $urandom_range(5, 30);
		recv_idle_pct = $urandom_range(5, 30);
		queue_random_cmds(120);
		settle();

		write_enforce(1'b0);
		send_idle_pct = $urandom_range(5, 30);
		recv_idle_pct = $urandom_range(5, 30);
		queue_random_cmds(90);
		settle();

		write_enforce(1'b1);
		send_idle_pct = $urandom_range(5, 30);
		recv_idle_pct = $urandom_range(5, 30);
		queue_random_cmds(90);
		settle();

		// full rate on both sides to close
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_cmds(55);
		settle();

		if (table_outputs_due.size() != 0) begin
			$error("%0d expected outputs never arrived", table_outputs_due.size());
			fail_count++;
		end
		$display("%0d commands taken, %0d outputs checked", cmds_taken, outputs_checked);
		$display("%0d tick writes and %0d refused freezes on a full table",
			writes_predicted, overflows_predicted);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[memory_freeze_table_core.f]
rtl/mft_pkg.sv
rtl/mft_cell.sv
rtl/mft_chain.sv
rtl/memory_freeze_table_core.sv
rtl/mft_checker.sv
bench/tb_top.sv
